### hdl/usb_endpoint_transfer_engine_macros.svh
// assertion macros shared by the transfer engine rtl
// no dependencies; expects clk_i and rst_ni in the including module
`ifndef USB_ENDPOINT_TRANSFER_ENGINE_MACROS_SVH
`define USB_ENDPOINT_TRANSFER_ENGINE_MACROS_SVH

// property checked on every rising edge outside reset
`define UETE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define UETE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### hdl/uete_pkg.sv
// types and constants for the usb endpoint transfer engine
// no dependencies
package uete_pkg;

  localparam int unsigned NUM_EP = 16;
  localparam int unsigned EP_AW  = (NUM_EP > 1) ? $clog2(NUM_EP) : 1;

  localparam logic [7:0] MAX_PACKET_RST = 8'd64;

  localparam logic [7:0] BD_OWN   = 8'h80;
  localparam logic [7:0] BD_DTS   = 8'h40;
  localparam logic [7:0] BD_DTSEN = 8'h08;
  localparam logic [7:0] BD_STALL = 8'h04;

  typedef enum logic [1:0] {
    OP_SETUP = 2'd0,
    OP_IN    = 2'd1,
    OP_OUT   = 2'd2,
    OP_SYNC  = 2'd3
  } opcode_e;

  typedef enum logic [2:0] {
    RESP_NONE  = 3'd0,
    RESP_ACK   = 3'd1,
    RESP_STALL = 3'd2,
    RESP_ROM   = 3'd3,
    RESP_RAM   = 3'd4
  } resp_e;

  typedef enum logic [2:0] {
    XS_IDLE  = 3'd0,
    XS_ACK   = 3'd1,
    XS_STALL = 3'd2,
    XS_ROM   = 3'd3,
    XS_RAM   = 3'd4
  } xfer_st_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_LOOKUP,
    FSM_RESULT
  } fsm_e;

  typedef struct packed {
    logic [3:0]  endpoint;
    logic [1:0]  opcode;
    logic [2:0]  response;
    logic [15:0] send_length;
  } in_word_t;

  typedef struct packed {
    logic        bd_written;
    logic [7:0]  out_count;
    logic [7:0]  out_status;
    logic [7:0]  in_count;
    logic [7:0]  in_status;
    logic [7:0]  copy_length;
    logic [15:0] copy_offset;
    logic        copy_from_rom;
    logic        busy_ignored;
  } out_word_t;

  typedef struct packed {
    xfer_st_e    status;
    logic [15:0] remaining;
    logic [15:0] offset;
  } ep_entry_t;

endpackage

### hdl/usb_endpoint_transfer_engine.sv
// usb endpoint transfer engine: data toggles and packetizer per endpoint
// depends on uete_pkg and usb_endpoint_transfer_engine_macros.svh
// result: registered in the lookup state after accept, held valid in the result state until taken
// one word in flight: the fsm steps idle, lookup, result and takes no new word until the
// result is taken, around the read-modify-write of the endpoint state memory (registered read)
// reset: async active low; clears fsm, entry valid bits, toggles, max_packet to 64
`include "usb_endpoint_transfer_engine_macros.svh"

module usb_endpoint_transfer_engine (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  uete_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output uete_pkg::out_word_t out_word_o,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_data_i
);

  uete_pkg::fsm_e state_q, state_d;

  logic [7:0] max_packet_q;

  uete_pkg::ep_entry_t mem [uete_pkg::NUM_EP];
  logic [uete_pkg::NUM_EP-1:0] vld_q;
  logic [uete_pkg::NUM_EP-1:0] in_tog_q, in_tog_d;
  logic [uete_pkg::NUM_EP-1:0] out_tog_q, out_tog_d;

  uete_pkg::ep_entry_t rd_data_q;
  logic                rd_vld_q;
  logic [uete_pkg::EP_AW-1:0] ep_q;
  logic [1:0]          op_q;
  logic [2:0]          resp_q;
  logic [15:0]         len_q;
  logic                skip_q;
  logic                cur_tog_q;
  logic                cur_tog_d;

  logic                       in_acc;
  logic                       in_range;
  logic [uete_pkg::EP_AW-1:0] in_ep;

  uete_pkg::ep_entry_t cur;
  uete_pkg::ep_entry_t nxt;
  uete_pkg::out_word_t res_d, res_q;
  logic                busy;
  logic                mem_we;
  logic [7:0]          size;
  logic [7:0]          dts_status;
  logic [15:0]         rem_left;

  assign in_acc   = in_valid_i && in_ready_o;
  assign in_ep    = in_word_i.endpoint[uete_pkg::EP_AW-1:0];
  assign in_range = {1'b0, in_word_i.endpoint} < 5'(uete_pkg::NUM_EP);

  // fsm next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      uete_pkg::FSM_IDLE: begin
        if (in_valid_i) state_d = uete_pkg::FSM_LOOKUP;
      end
      uete_pkg::FSM_LOOKUP: state_d = uete_pkg::FSM_RESULT;
      uete_pkg::FSM_RESULT: begin
        if (out_ready_i) state_d = uete_pkg::FSM_IDLE;
      end
      default: state_d = uete_pkg::FSM_IDLE;
    endcase
  end

  // fsm outputs
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    mem_we      = 1'b0;
    unique case (state_q)
      uete_pkg::FSM_IDLE:   in_ready_o  = 1'b1;
      uete_pkg::FSM_LOOKUP: mem_we      = !skip_q;
      uete_pkg::FSM_RESULT: out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= uete_pkg::FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_packet_q <= uete_pkg::MAX_PACKET_RST;
    end else if (cfg_we_i) begin
      max_packet_q <= cfg_data_i;
    end
  end

  // toggle update at accept
  always_comb begin
    in_tog_d  = in_tog_q;
    out_tog_d = out_tog_q;
    cur_tog_d = 1'b0;
    if (in_word_i.opcode == uete_pkg::OP_SYNC) begin
      in_tog_d  = '0;
      out_tog_d = '0;
    end else if (in_range) begin
      unique case (in_word_i.opcode)
        uete_pkg::OP_SETUP: begin
          in_tog_d[in_ep]  = 1'b1;
          out_tog_d[in_ep] = 1'b1;
          cur_tog_d        = 1'b1;
        end
        uete_pkg::OP_IN: begin
          in_tog_d[in_ep] = !in_tog_q[in_ep];
          cur_tog_d       = !in_tog_q[in_ep];
        end
        default: begin
          out_tog_d[in_ep] = !out_tog_q[in_ep];
          cur_tog_d        = !out_tog_q[in_ep];
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_tog_q  <= '0;
      out_tog_q <= '0;
    end else if (in_acc) begin
      in_tog_q  <= in_tog_d;
      out_tog_q <= out_tog_d;
    end
  end

  // state memory, registered read
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd_data_q <= mem[in_ep];
    end
    if (mem_we) begin
      mem[ep_q] <= nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (in_acc) rd_vld_q <= vld_q[in_ep];
      if (mem_we) vld_q[ep_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ep_q      <= in_ep;
      op_q      <= in_word_i.opcode;
      resp_q    <= in_word_i.response;
      len_q     <= in_word_i.send_length;
      skip_q    <= (in_word_i.opcode == uete_pkg::OP_SYNC) || !in_range;
      cur_tog_q <= cur_tog_d;
    end
  end

  // modify
  always_comb begin
    cur = rd_vld_q ? rd_data_q
                   : uete_pkg::ep_entry_t'{status: uete_pkg::XS_IDLE, remaining: '0,
                                            offset: '0};
    busy = (op_q != uete_pkg::OP_SETUP) && (cur.status != uete_pkg::XS_IDLE);
    nxt  = cur;
    if (!busy) begin
      case (resp_q)
        uete_pkg::RESP_ACK:   nxt.status = uete_pkg::XS_ACK;
        uete_pkg::RESP_STALL: nxt.status = uete_pkg::XS_STALL;
        uete_pkg::RESP_ROM, uete_pkg::RESP_RAM: begin
          nxt.status    = (resp_q == uete_pkg::RESP_ROM) ? uete_pkg::XS_ROM
                                                         : uete_pkg::XS_RAM;
          nxt.remaining = len_q;
          nxt.offset    = '0;
        end
        default: ;
      endcase
    end

    size       = (nxt.remaining > {8'd0, max_packet_q}) ? max_packet_q : nxt.remaining[7:0];
    rem_left   = nxt.remaining - {8'd0, size};
    dts_status = cur_tog_q ? (uete_pkg::BD_OWN | uete_pkg::BD_DTSEN | uete_pkg::BD_DTS)
                           : (uete_pkg::BD_OWN | uete_pkg::BD_DTSEN);

    res_d = '0;
    res_d.busy_ignored = busy;
    unique case (nxt.status)
      uete_pkg::XS_ACK: begin
        res_d.bd_written = 1'b1;
        res_d.out_count  = max_packet_q;
        res_d.out_status = uete_pkg::BD_OWN;
        res_d.in_status  = dts_status;
        nxt.status       = uete_pkg::XS_IDLE;
      end
      uete_pkg::XS_STALL: begin
        res_d.bd_written = 1'b1;
        res_d.out_status = uete_pkg::BD_OWN | uete_pkg::BD_STALL;
        res_d.in_status  = uete_pkg::BD_OWN | uete_pkg::BD_STALL;
        nxt.status       = uete_pkg::XS_IDLE;
      end
      uete_pkg::XS_ROM, uete_pkg::XS_RAM: begin
        res_d.bd_written    = 1'b1;
        res_d.out_count     = max_packet_q;
        res_d.out_status    = uete_pkg::BD_OWN;
        res_d.in_count      = size;
        res_d.in_status     = dts_status;
        res_d.copy_length   = size;
        res_d.copy_offset   = nxt.offset;
        res_d.copy_from_rom = (nxt.status == uete_pkg::XS_ROM);
        nxt.offset          = nxt.offset + {8'd0, size};
        nxt.remaining       = rem_left;
        if (rem_left == '0) nxt.status = uete_pkg::XS_IDLE;
      end
      default: ;
    endcase
    if (skip_q) res_d = '0;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == uete_pkg::FSM_LOOKUP) begin
      res_q <= res_d;
    end
  end

  assign out_word_o = res_q;

  `UETE_ASSERT_IMP(a_one_in_flight, out_valid_o, !in_ready_o, "input taken while result pending")
  `UETE_ASSERT_IMP(a_we_in_lookup, mem_we, state_q == uete_pkg::FSM_LOOKUP,
                   "state write outside lookup")
  `UETE_ASSERT_IMP(a_idle_zero, out_valid_o && !out_word_o.bd_written,
                   out_word_o.in_status == '0 && out_word_o.copy_length == '0,
                   "fields set without descriptor write")
  `UETE_ASSERT_IMP(a_stall_both,
                   out_valid_o && out_word_o.out_status == (uete_pkg::BD_OWN | uete_pkg::BD_STALL),
                   out_word_o.in_status == (uete_pkg::BD_OWN | uete_pkg::BD_STALL),
                   "stall armed on one direction only")
  `UETE_ASSERT(a_accept_to_lookup, in_acc |=> state_q == uete_pkg::FSM_LOOKUP,
               "accept did not start lookup")

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// testbench for usb_endpoint_transfer_engine: directed table then random token traffic,
// every descriptor word checked against the table's expected word or an in-bench model of toggles and packetizing
// depends on uete_pkg and the engine rtl
module tb_top;
  import uete_pkg::*;

  localparam logic [7:0] ST_NORMAL = BD_OWN;
  localparam logic [7:0] ST_DATA0  = BD_OWN | BD_DTSEN;
  localparam logic [7:0] ST_DATA1  = BD_OWN | BD_DTSEN | BD_DTS;
  localparam logic [7:0] ST_HALT   = BD_OWN | BD_STALL;

  // responses with no meaning, treated as none
  localparam logic [2:0] RESP_RSVD5 = 3'd5;
  localparam logic [2:0] RESP_RSVD6 = 3'd6;
  localparam logic [2:0] RESP_RSVD7 = 3'd7;

  localparam int NUM_DIRECTED = 22;
  localparam int NUM_PHASES   = 6;
  localparam int PHASE_WORDS  = 72;

  typedef struct packed {
    in_word_t  w;
    logic      typed;
    out_word_t want;
  } table_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_word_o;
  logic      cfg_we_i = 1'b0;
  logic [7:0] cfg_data_i = '0;

  usb_endpoint_transfer_engine dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // engine state as the bench sees it
  logic [7:0]  packet_cap = MAX_PACKET_RST;
  xfer_st_e    ep_status [NUM_EP];
  logic        tog_in    [NUM_EP];
  logic        tog_out   [NUM_EP];
  logic        tog_cur   [NUM_EP];
  logic [15:0] bytes_left [NUM_EP];
  logic [15:0] src_offset [NUM_EP];

  out_word_t pending_bd_q [$];
  logic      mismatch_seen = 1'b0;
  logic      smooth = 1'b0;
  int        burst_left = 0;
  int        hold_asked = 0;
  int        hold_seen = 0;
  int        rx_stall = 0;
  int        words_sent = 0;

  table_row_t directed_rows [NUM_DIRECTED] = '{
    '{'{4'd0, OP_SETUP, RESP_ACK, 16'd0}, 1'b1,
      '{1'b1, 8'd64, ST_NORMAL, 8'd0, ST_DATA1, 8'd0, 16'd0, 1'b0, 1'b0}},
    '{'{4'd0, OP_IN, RESP_NONE, 16'd0}, 1'b1, '0},
    '{'{4'd1, OP_SETUP, RESP_STALL, 16'd0}, 1'b1,
      '{1'b1, 8'd0, ST_HALT, 8'd0, ST_HALT, 8'd0, 16'd0, 1'b0, 1'b0}},
    '{'{4'd2, OP_SETUP, RESP_ROM, 16'd0}, 1'b1,
      '{1'b1, 8'd64, ST_NORMAL, 8'd0, ST_DATA1, 8'd0, 16'd0, 1'b1, 1'b0}},
    '{'{4'd3, OP_SETUP, RESP_RAM, 16'hFFFF}, 1'b1,
      '{1'b1, 8'd64, ST_NORMAL, 8'd64, ST_DATA1, 8'd64, 16'd0, 1'b0, 1'b0}},
    '{'{4'd3, OP_IN, RESP_ACK, 16'd0}, 1'b0, '0},
    '{'{4'd3, OP_OUT, RESP_STALL, 16'd0}, 1'b0, '0},
    '{'{4'd3, OP_IN, RESP_RAM, 16'd5}, 1'b0, '0},
    '{'{4'd4, OP_SETUP, RESP_ROM, 16'd130}, 1'b1,
      '{1'b1, 8'd64, ST_NORMAL, 8'd64, ST_DATA1, 8'd64, 16'd0, 1'b1, 1'b0}},
    '{'{4'd4, OP_IN, RESP_NONE, 16'd0}, 1'b0, '0},
    '{'{4'd4, OP_IN, RESP_NONE, 16'd0}, 1'b0, '0},
    '{'{4'd4, OP_IN, RESP_NONE, 16'd0}, 1'b0, '0},
    '{'{4'd3, OP_SETUP, RESP_ACK, 16'd0}, 1'b1,
      '{1'b1, 8'd64, ST_NORMAL, 8'd0, ST_DATA1, 8'd0, 16'd0, 1'b0, 1'b0}},
    '{'{4'd15, OP_SYNC, RESP_RSVD7, 16'hFFFF}, 1'b1, '0},
    '{'{4'd15, OP_IN, RESP_RSVD5, 16'hFFFF}, 1'b1, '0},
    '{'{4'd15, OP_OUT, RESP_RSVD6, 16'hFFFF}, 1'b1, '0},
    '{'{4'd15, OP_IN, RESP_RSVD7, 16'd0}, 1'b1, '0},
    '{'{4'd5, OP_IN, RESP_ACK, 16'd0}, 1'b0, '0},
    '{'{4'd5, OP_OUT, RESP_ROM, 16'hFFFF}, 1'b0, '0},
    '{'{4'd5, OP_SETUP, RESP_RAM, 16'd1}, 1'b0, '0},
    '{'{4'd14, OP_OUT, RESP_STALL, 16'd0}, 1'b0, '0},
    '{'{4'd0, OP_IN, RESP_ROM, 16'h8000}, 1'b0, '0}
  };

  function automatic out_word_t rearm_endpoint(in_word_t w);
    out_word_t   r;
    int          e;
    logic [15:0] size;
    r = '0;
    e = int'(w.endpoint);
    if (w.opcode == OP_SYNC) begin
      for (int i = 0; i < NUM_EP; i++) begin
        tog_in[i] = 1'b0;
        tog_out[i] = 1'b0;
        tog_cur[i] = 1'b0;
      end
      return r;
    end
    case (w.opcode)
      OP_SETUP: begin
        tog_in[e] = 1'b1;
        tog_out[e] = 1'b1;
        tog_cur[e] = 1'b1;
      end
      OP_IN: begin
        tog_in[e] = ~tog_in[e];
        tog_cur[e] = tog_in[e];
      end
      default: begin
        tog_out[e] = ~tog_out[e];
        tog_cur[e] = tog_out[e];
      end
    endcase
    if (w.opcode != OP_SETUP && ep_status[e] != XS_IDLE) begin
      r.busy_ignored = 1'b1;
    end else begin
      case (w.response)
        RESP_ACK:   ep_status[e] = XS_ACK;
        RESP_STALL: ep_status[e] = XS_STALL;
        RESP_ROM, RESP_RAM: begin
          ep_status[e] = (w.response == RESP_ROM) ? XS_ROM : XS_RAM;
          bytes_left[e] = w.send_length;
          src_offset[e] = '0;
        end
        default: ;
      endcase
    end
    case (ep_status[e])
      XS_ACK: begin
        r.bd_written = 1'b1;
        r.out_count = packet_cap;
        r.out_status = ST_NORMAL;
        r.in_status = tog_cur[e] ? ST_DATA1 : ST_DATA0;
        ep_status[e] = XS_IDLE;
      end
      XS_STALL: begin
        r.bd_written = 1'b1;
        r.out_status = ST_HALT;
        r.in_status = ST_HALT;
        ep_status[e] = XS_IDLE;
      end
      XS_ROM, XS_RAM: begin
        size = (bytes_left[e] > packet_cap) ? {8'd0, packet_cap} : bytes_left[e];
        r.bd_written = 1'b1;
        r.out_count = packet_cap;
        r.out_status = ST_NORMAL;
        r.in_count = size[7:0];
        r.in_status = tog_cur[e] ? ST_DATA1 : ST_DATA0;
        r.copy_length = size[7:0];
        r.copy_offset = src_offset[e];
        r.copy_from_rom = (ep_status[e] == XS_ROM);
        src_offset[e] = src_offset[e] + size;
        bytes_left[e] = bytes_left[e] - size;
        if (bytes_left[e] == 16'd0) ep_status[e] = XS_IDLE;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic cmp_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatch_seen = 1'b1;
    end
  endtask

  task automatic check_word(out_word_t got);
    out_word_t want;
    if (pending_bd_q.size() == 0) begin
      $display("%0t: word with none expected, actual %h", $time, got);
      mismatch_seen = 1'b1;
    end else begin
      want = pending_bd_q.pop_front();
      cmp_field("bd_written", 16'(want.bd_written), 16'(got.bd_written));
      cmp_field("out_count", 16'(want.out_count), 16'(got.out_count));
      cmp_field("out_status", 16'(want.out_status), 16'(got.out_status));
      cmp_field("in_count", 16'(want.in_count), 16'(got.in_count));
      cmp_field("in_status", 16'(want.in_status), 16'(got.in_status));
      cmp_field("copy_length", 16'(want.copy_length), 16'(got.copy_length));
      cmp_field("copy_offset", want.copy_offset, got.copy_offset);
      cmp_field("copy_from_rom", 16'(want.copy_from_rom), 16'(got.copy_from_rom));
      cmp_field("busy_ignored", 16'(want.busy_ignored), 16'(got.busy_ignored));
    end
  endtask

  // called at a rising edge; returns at the edge the word is taken
  task automatic offer_word(in_word_t w, logic typed, out_word_t want);
    int        gap;
    out_word_t exp;
    if (burst_left > 0 || smooth) begin
      gap = 0;
      if (burst_left > 0) burst_left--;
    end else begin
      gap = $urandom_range(0, 9);
      gap = (gap < 6) ? 0 : (gap < 9) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    exp = rearm_endpoint(w);
    pending_bd_q.push_back(typed ? want : exp);
    words_sent++;
  endtask

  task automatic drain_words();
    in_valid_i <= 1'b0;
    while (pending_bd_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_max_packet(logic [7:0] v);
    drain_words();
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    packet_cap = v;
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [15:0] pick_length();
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 3 * packet_cap + 2));
  endfunction

  task automatic random_traffic(int target);
    in_word_t w;
    int       n;
    int       stop_at;
    stop_at = words_sent + target;
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 9) < 6) begin
        w.endpoint = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, 3)) : 4'($urandom);
        w.opcode = OP_SETUP;
        w.response = ($urandom_range(0, 9) < 6) ? 3'($urandom_range(RESP_ROM, RESP_RAM))
                                                : 3'($urandom_range(RESP_NONE, RESP_STALL));
        w.send_length = pick_length();
        offer_word(w, 1'b0, '0);
        n = $urandom_range(1, 6);
        repeat (n) begin
          w.opcode = ($urandom_range(0, 4) != 0) ? OP_IN : OP_OUT;
          w.response = ($urandom_range(0, 1) != 0) ? RESP_NONE : 3'($urandom_range(0, 7));
          w.send_length = pick_length();
          offer_word(w, 1'b0, '0);
        end
      end else begin
        w.endpoint = 4'($urandom);
        w.opcode = 2'($urandom);
        w.response = 3'($urandom);
        w.send_length = 16'($urandom);
        offer_word(w, 1'b0, '0);
      end
    end
  endtask

  initial begin
    logic [7:0] cap_plan [NUM_PHASES];
    for (int i = 0; i < NUM_EP; i++) begin
      ep_status[i] = XS_IDLE;
      tog_in[i] = 1'b0;
      tog_out[i] = 1'b0;
      tog_cur[i] = 1'b0;
      bytes_left[i] = '0;
      src_offset[i] = '0;
    end
    cap_plan = '{8'd255, 8'd0, 8'd1, 8'($urandom_range(2, 254)), 8'd16, 8'd255};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      offer_word(directed_rows[i].w, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_max_packet(cap_plan[p]);
      smooth = (p == 4);
      if (p == 2) begin
        // hold off the result side while words are offered back to back
        hold_asked++;
        burst_left = 16;
      end
      if (p == 1) begin
        random_traffic(PHASE_WORDS / 2);
        drain_words();
        random_traffic(PHASE_WORDS / 2);
      end else begin
        random_traffic(PHASE_WORDS);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_bd_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (!mismatch_seen) begin
      $display("usb_endpoint_transfer_engine verification clean");
    end else begin
      $display("usb_endpoint_transfer_engine verification failed");
    end
    $finish;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) check_word(out_word_o);
      if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        rx_stall = 120;
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_ready_i <= 1'b0;
      end else if (smooth || $urandom_range(0, 9) < 7) begin
        out_ready_i <= 1'b1;
      end else begin
        rx_stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        out_ready_i <= 1'b0;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("usb_endpoint_transfer_engine verification failed");
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/uete_pkg.sv
hdl/usb_endpoint_transfer_engine.sv
sim/tb_top.sv
